// ----- design/mrs_pkg.sv -----
// shared types, codes and the crc fold for the modbus rtu responder
// no dependencies; imported by the core and its checker
package mrs_pkg;

  // item kinds on the request channel
  localparam logic [2:0] ITEM_FRAME    = 3'd0;
  localparam logic [2:0] ITEM_SET_DISC = 3'd1;
  localparam logic [2:0] ITEM_SET_COIL = 3'd2;
  localparam logic [2:0] ITEM_SET_INP  = 3'd3;
  localparam logic [2:0] ITEM_SET_HOLD = 3'd4;

  // modbus function codes
  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_DISC   = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_READ_INP    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  localparam logic [7:0] EXC_FLAG       = 8'h80;
  localparam logic [7:0] EXC_BAD_FUNC   = 8'h01;
  localparam logic [7:0] EXC_BAD_ADDR   = 8'h02;

  localparam logic [1:0] NOTICE_NONE    = 2'd0;
  localparam logic [1:0] NOTICE_COIL    = 2'd1;
  localparam logic [1:0] NOTICE_HOLD    = 2'd2;

  localparam int unsigned MIN_FRAME     = 8;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR,
    S_DEC,
    S_HEAD,
    S_BRD,
    S_BACC,
    S_BEMIT,
    S_WRD,
    S_WHI,
    S_WLO
  } state_e;

  typedef enum logic [1:0] {
    K_EXC,
    K_RBITS,
    K_RWORDS,
    K_WRITE
  } kind_e;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/modbus_rtu_slave_responder_core.sv -----
// modbus rtu slave responder core: frame store, table memories, reply sequencer
// depends on mrs_pkg
//
// usage:
//   request channel (in_valid_i / in_stall_o): func_i 0 carries a frame byte in
//   rx_byte_i with frame_end_i on the last one; func_i 1..4 load an entry of the
//   discrete, coil, input or holding table from table_index_i / table_value_i.
//   reply channel (out_valid_o / out_stall_i): tx_byte_o bytes of the answer,
//   last_o on the final one, write_notice_o on that byte for write requests.
//   frame bytes and table loads are taken one per cycle while the core is idle.
//   after a frame end that passes length and crc the core raises in_stall_o,
//   reads header bytes 0..5 from the frame memory, decodes them, then emits the
//   reply: header or echo bytes, then register words read one at a time and
//   sent high byte first, or packed bit bytes gathered one entry at a time from
//   the single read port of each table memory. frames failing length or crc are
//   dropped with no stall; a station id mismatch drops the frame after the
//   header is decoded under stall. a stalled reply byte holds in the output
//   register and the sequencer waits. reset clears frame count and table valid
//   bits and sets crc to CRC_INIT and station_id to 1; the frame memory itself
//   needs no clearing since a frame only reads its bytes. station_id is written
//   through cfg_we_i / cfg_wdata_i, by the user only while idle; not enforced.
module modbus_rtu_slave_responder_core #(
  parameter int unsigned FRAME_DEPTH   = 64,
  parameter int unsigned DISC_COUNT    = 64,
  parameter int unsigned COIL_COUNT    = 64,
  parameter int unsigned INPUT_COUNT   = 16,
  parameter int unsigned HOLDING_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [5:0]  table_index_i,
  input  logic [15:0] table_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [1:0]  write_notice_o
);
  import mrs_pkg::*;

  localparam int unsigned AW  = $clog2(FRAME_DEPTH);
  localparam int unsigned CW  = $clog2(FRAME_DEPTH + 2);
  // only the first 64 entries can be loaded, the rest read as zero
  localparam int unsigned DS  = (DISC_COUNT < 64) ? DISC_COUNT : 64;
  localparam int unsigned CS  = (COIL_COUNT < 64) ? COIL_COUNT : 64;
  localparam int unsigned IS  = (INPUT_COUNT < 64) ? INPUT_COUNT : 64;
  localparam int unsigned HS  = (HOLDING_COUNT < 64) ? HOLDING_COUNT : 64;
  localparam int unsigned DIW = (DS > 1) ? $clog2(DS) : 1;
  localparam int unsigned CIW = (CS > 1) ? $clog2(CS) : 1;
  localparam int unsigned IIW = (IS > 1) ? $clog2(IS) : 1;
  localparam int unsigned HIW = (HS > 1) ? $clog2(HS) : 1;

  state_e state_q, state_d;

  logic [7:0]    station_q;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   crc_q, crc_d, crc_nx;
  logic [7:0]    b1_q, b1_d, b2_q, b2_d;

  logic accept, frame_acc, frame_ok;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_acc  = accept && (func_i == ITEM_FRAME);
  assign in_stall_o = (state_q != S_IDLE);

  // frame memory
  logic [7:0] fs_mem [FRAME_DEPTH];
  logic [7:0] fs_rdata_q;
  logic       fs_we, fs_re;
  logic [2:0] hidx_q, hidx_d;
  logic [7:0] hdr_q [6];

  assign fs_we = frame_acc && (count_q < CW'(FRAME_DEPTH));

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[count_q[AW-1:0]] <= rx_byte_i;
    if (fs_re) fs_rdata_q <= fs_mem[AW'(hidx_q)];
  end

  // crc folds the byte two positions behind the one being stored
  always_comb begin
    crc_nx  = (count_q >= CW'(2)) ? crc_fold(crc_q, b2_q) : crc_q;
    count_d = count_q;
    crc_d   = crc_q;
    b1_d    = b1_q;
    b2_d    = b2_q;
    if (frame_acc) begin
      if (count_q < CW'(FRAME_DEPTH)) begin
        crc_d   = crc_nx;
        b2_d    = b1_q;
        b1_d    = rx_byte_i;
        count_d = count_q + CW'(1);
      end else begin
        count_d = CW'(FRAME_DEPTH + 1);
      end
      if (frame_end_i) begin
        count_d = '0;
        crc_d   = CRC_INIT;
      end
    end
  end

  assign frame_ok = (count_q < CW'(FRAME_DEPTH)) && (count_q >= CW'(MIN_FRAME - 1)) &&
                    (b1_q == crc_nx[7:0]) && (rx_byte_i == crc_nx[15:8]);

  // table memories with per-entry valid bits cleared at reset
  logic          disc_mem [DS];
  logic          coil_mem [CS];
  logic [15:0]   inp_mem  [IS];
  logic [15:0]   hold_mem [HS];
  logic [DS-1:0] disc_vld_q;
  logic [CS-1:0] coil_vld_q;
  logic [IS-1:0] inp_vld_q;
  logic [HS-1:0] hold_vld_q;

  logic        we_disc, we_coil, we_inp, we_hold;
  assign we_disc = accept && (func_i == ITEM_SET_DISC) && (32'(table_index_i) < DISC_COUNT);
  assign we_coil = accept && (func_i == ITEM_SET_COIL) && (32'(table_index_i) < COIL_COUNT);
  assign we_inp  = accept && (func_i == ITEM_SET_INP)  && (32'(table_index_i) < INPUT_COUNT);
  assign we_hold = accept && (func_i == ITEM_SET_HOLD) && (32'(table_index_i) < HOLDING_COUNT);

  logic [15:0] ptr_q, ptr_d;
  logic        bit_re, word_re;
  logic        disc_rd_q, coil_rd_q;
  logic [15:0] inp_rd_q, hold_rd_q;
  logic        disc_hit, coil_hit, inp_hit, hold_hit;

  assign disc_hit = ptr_q < 16'(DS);
  assign coil_hit = ptr_q < 16'(CS);
  assign inp_hit  = ptr_q < 16'(IS);
  assign hold_hit = ptr_q < 16'(HS);

  always_ff @(posedge clk_i) begin
    if (we_disc) disc_mem[table_index_i[DIW-1:0]] <= table_value_i[0];
    if (we_coil) coil_mem[table_index_i[CIW-1:0]] <= table_value_i[0];
    if (we_inp)  inp_mem[table_index_i[IIW-1:0]]  <= table_value_i;
    if (we_hold) hold_mem[table_index_i[HIW-1:0]] <= table_value_i;
    if (bit_re) begin
      disc_rd_q <= disc_hit && disc_vld_q[ptr_q[DIW-1:0]] && disc_mem[ptr_q[DIW-1:0]];
      coil_rd_q <= coil_hit && coil_vld_q[ptr_q[CIW-1:0]] && coil_mem[ptr_q[CIW-1:0]];
    end
    if (word_re) begin
      inp_rd_q  <= (inp_hit && inp_vld_q[ptr_q[IIW-1:0]]) ? inp_mem[ptr_q[IIW-1:0]] : '0;
      hold_rd_q <= (hold_hit && hold_vld_q[ptr_q[HIW-1:0]]) ? hold_mem[ptr_q[HIW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_vld_q <= '0;
      coil_vld_q <= '0;
      inp_vld_q  <= '0;
      hold_vld_q <= '0;
    end else begin
      if (we_disc) disc_vld_q[table_index_i[DIW-1:0]] <= 1'b1;
      if (we_coil) coil_vld_q[table_index_i[CIW-1:0]] <= 1'b1;
      if (we_inp)  inp_vld_q[table_index_i[IIW-1:0]]  <= 1'b1;
      if (we_hold) hold_vld_q[table_index_i[HIW-1:0]] <= 1'b1;
    end
  end

  // decode of the header
  kind_e       kind_q, kind_d;
  logic        sel_q, sel_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  cnt_byte_q, cnt_byte_d;
  logic [1:0]  notice_q, notice_d;
  logic [15:0] rem_q, rem_d;
  logic [13:0] dcnt_q, dcnt_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [2:0]  j_q, j_d;
  logic [7:0]  acc_q, acc_d;
  logic        taken_q, taken_d;
  logic        drop;

  logic [15:0] dec_addr, dec_qty, dec_qeff;
  logic [16:0] dec_end, dec_size, dec_bytes;
  kind_e       dec_kind;
  logic        dec_sel;
  logic [1:0]  dec_notice;

  always_comb begin
    dec_addr   = {hdr_q[2], hdr_q[3]};
    dec_qty    = {hdr_q[4], hdr_q[5]};
    dec_qeff   = dec_qty;
    dec_size   = '0;
    dec_kind   = K_EXC;
    dec_sel    = 1'b0;
    dec_notice = NOTICE_NONE;
    unique case (hdr_q[1])
      FC_READ_DISC: begin
        dec_kind = K_RBITS;
        dec_size = 17'(DISC_COUNT);
      end
      FC_READ_COILS: begin
        dec_kind = K_RBITS;
        dec_sel  = 1'b1;
        dec_size = 17'(COIL_COUNT);
      end
      FC_READ_INP: begin
        dec_kind = K_RWORDS;
        dec_size = 17'(INPUT_COUNT);
      end
      FC_READ_HOLD: begin
        dec_kind = K_RWORDS;
        dec_sel  = 1'b1;
        dec_size = 17'(HOLDING_COUNT);
      end
      FC_WRITE_COIL, FC_WRITE_COILS: begin
        dec_kind   = K_WRITE;
        dec_notice = NOTICE_COIL;
        dec_size   = 17'(COIL_COUNT);
        if (hdr_q[1] == FC_WRITE_COIL) dec_qeff = 16'd1;
      end
      FC_WRITE_REG, FC_WRITE_REGS: begin
        dec_kind   = K_WRITE;
        dec_notice = NOTICE_HOLD;
        dec_size   = 17'(HOLDING_COUNT);
        if (hdr_q[1] == FC_WRITE_REG) dec_qeff = 16'd1;
      end
      default: dec_kind = K_EXC;
    endcase
    dec_end   = {1'b0, dec_addr} + {1'b0, dec_qeff};
    dec_bytes = ({1'b0, dec_qty} + 17'd7) >> 3;
  end

  // sequencer: emission request and memory reads
  logic       emit, out_free, fire;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic [1:0] emit_notice;

  assign out_free = !out_valid_o || !out_stall_i;
  assign fire     = emit && out_free;

  always_comb begin
    emit        = 1'b0;
    emit_byte   = '0;
    emit_last   = 1'b0;
    emit_notice = NOTICE_NONE;
    fs_re       = 1'b0;
    bit_re      = 1'b0;
    word_re     = 1'b0;
    unique case (state_q)
      S_HDR:  fs_re  = (hidx_q < 3'd6);
      S_BRD:  bit_re = 1'b1;
      S_WRD:  word_re = 1'b1;
      S_HEAD: begin
        emit = 1'b1;
        unique case (hcnt_q)
          3'd0: emit_byte = station_q;
          3'd1: emit_byte = (kind_q == K_EXC) ? code_q : hdr_q[1];
          3'd2: emit_byte = (kind_q == K_EXC) ? cnt_byte_q :
                            (kind_q == K_WRITE) ? hdr_q[2] : cnt_byte_q;
          3'd3: emit_byte = hdr_q[3];
          3'd4: emit_byte = hdr_q[4];
          3'd5: emit_byte = hdr_q[5];
          default: emit_byte = '0;
        endcase
        priority case (kind_q)
          K_EXC:    emit_last = (hcnt_q == 3'd2);
          K_RBITS:  emit_last = (hcnt_q == 3'd2) && (dcnt_q == '0);
          K_RWORDS: emit_last = (hcnt_q == 3'd2) && (rem_q == '0);
          default:  emit_last = (hcnt_q == 3'd5);
        endcase
        if (emit_last) emit_notice = notice_q;
      end
      S_BEMIT: begin
        emit      = 1'b1;
        emit_byte = acc_q;
        emit_last = (dcnt_q == 14'd1);
      end
      S_WHI: begin
        emit      = 1'b1;
        emit_byte = sel_q ? hold_rd_q[15:8] : inp_rd_q[15:8];
      end
      S_WLO: begin
        emit      = 1'b1;
        emit_byte = sel_q ? hold_rd_q[7:0] : inp_rd_q[7:0];
        emit_last = (rem_q == '0);
      end
      default: ;
    endcase
  end

  assign drop = (hdr_q[0] != station_q);

  always_comb begin
    state_d    = state_q;
    hidx_d     = hidx_q;
    kind_d     = kind_q;
    sel_d      = sel_q;
    code_d     = code_q;
    cnt_byte_d = cnt_byte_q;
    notice_d   = notice_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    ptr_d      = ptr_q;
    hcnt_d     = hcnt_q;
    j_d        = j_q;
    acc_d      = acc_q;
    taken_d    = taken_q;
    unique case (state_q)
      S_IDLE: begin
        hidx_d = '0;
        if (frame_acc && frame_end_i && frame_ok) state_d = S_HDR;
      end
      S_HDR: begin
        hidx_d = hidx_q + 3'd1;
        if (hidx_q == 3'd6) state_d = S_DEC;
      end
      S_DEC: begin
        hcnt_d     = '0;
        j_d        = '0;
        acc_d      = '0;
        ptr_d      = dec_addr;
        sel_d      = dec_sel;
        notice_d   = dec_notice;
        rem_d      = dec_qty;
        dcnt_d     = dec_bytes[13:0];
        kind_d     = dec_kind;
        code_d     = hdr_q[1] + EXC_FLAG;
        cnt_byte_d = (dec_kind == K_RBITS) ? dec_bytes[7:0] : {dec_qty[6:0], 1'b0};
        if (dec_kind == K_EXC) begin
          cnt_byte_d = EXC_BAD_FUNC;
        end else if (dec_end > dec_size) begin
          kind_d     = K_EXC;
          cnt_byte_d = EXC_BAD_ADDR;
          notice_d   = NOTICE_NONE;
        end
        state_d = drop ? S_IDLE : S_HEAD;
      end
      S_HEAD: begin
        if (fire) begin
          hcnt_d = hcnt_q + 3'd1;
          if (emit_last) state_d = S_IDLE;
          else if (hcnt_q == 3'd2 && kind_q == K_RBITS) state_d = S_BRD;
          else if (hcnt_q == 3'd2 && kind_q == K_RWORDS) state_d = S_WRD;
        end
      end
      S_BRD: begin
        taken_d = (rem_q != '0);
        if (rem_q != '0) begin
          rem_d = rem_q - 16'd1;
          ptr_d = ptr_q + 16'd1;
        end
        state_d = S_BACC;
      end
      S_BACC: begin
        acc_d[j_q] = taken_q && (sel_q ? coil_rd_q : disc_rd_q);
        j_d        = j_q + 3'd1;
        state_d    = (j_q == 3'd7) ? S_BEMIT : S_BRD;
      end
      S_BEMIT: begin
        if (fire) begin
          dcnt_d  = dcnt_q - 14'd1;
          acc_d   = '0;
          state_d = emit_last ? S_IDLE : S_BRD;
        end
      end
      S_WRD: begin
        rem_d   = rem_q - 16'd1;
        ptr_d   = ptr_q + 16'd1;
        state_d = S_WHI;
      end
      S_WHI: if (fire) state_d = S_WLO;
      S_WLO: if (fire) state_d = emit_last ? S_IDLE : S_WRD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_HDR && hidx_q != 3'd0) hdr_q[hidx_q - 3'd1] <= fs_rdata_q;
    kind_q     <= kind_d;
    sel_q      <= sel_d;
    code_q     <= code_d;
    cnt_byte_q <= cnt_byte_d;
    notice_q   <= notice_d;
    rem_q      <= rem_d;
    dcnt_q     <= dcnt_d;
    ptr_q      <= ptr_d;
    hcnt_q     <= hcnt_d;
    j_q        <= j_d;
    acc_q      <= acc_d;
    taken_q    <= taken_d;
    b1_q       <= b1_d;
    b2_q       <= b2_d;
    hidx_q     <= hidx_d;
    if (fire) begin
      tx_byte_o      <= emit_byte;
      last_o         <= emit_last;
      write_notice_o <= emit_notice;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      station_q   <= 8'd1;
      count_q     <= '0;
      crc_q       <= CRC_INIT;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      if (cfg_we_i) station_q <= cfg_wdata_i;
      if (fire) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

endmodule

// ----- design/mrs_checker.sv -----
// port-level checks for the modbus rtu responder core
// depends on mrs_pkg; bound to modbus_rtu_slave_responder_core below
module mrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  func_i,
  input logic        frame_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  tx_byte_o,
  input logic        last_o,
  input logic [1:0]  write_notice_o
);
  import mrs_pkg::*;

  // a notice only rides on the final byte of a reply
  a_notice_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_notice_o != NOTICE_NONE) |-> last_o)
    else $error("write notice on a non-final byte");

  a_notice_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_notice_o != 2'd3))
    else $error("undefined write notice");

  // the core only goes busy right after taking a frame end
  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && func_i == ITEM_FRAME && frame_end_i))
    else $error("busy without a frame end");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(tx_byte_o) && $stable(last_o)))
    else $error("stalled reply byte changed");

endmodule

bind modbus_rtu_slave_responder_core mrs_checker u_mrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .func_i         (func_i),
  .frame_end_i    (frame_end_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .tx_byte_o      (tx_byte_o),
  .last_o         (last_o),
  .write_notice_o (write_notice_o)
);
